[rtl/htc_pkg.sv]
// Shared types and constants for the half-space triangle coverage block.
// Used by the setup stage, the walk stage, the top level and the checker.
// No dependencies.
package htc_pkg;

    localparam int VERT_W    = 16;   // signed fixed-point vertex coordinate
    localparam int DELTA_W   = 17;   // vertex difference
    localparam int EDGE_W    = 36;   // edge function value
    localparam int PIX_W     = 12;   // reported pixel coordinate
    localparam int DIM_W     = 13;   // render target size register
    localparam int NUM_EDGES = 3;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_opcode;

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_index;

    typedef logic signed [VERT_W-1:0]  t_vert;
    typedef logic signed [DELTA_W-1:0] t_delta;
    typedef logic signed [EDGE_W-1:0]  t_edge;

    // Occupancy of the setup register as seen by the walk stage.
    typedef struct packed {
        logic vld;
        logic is_load;
    } t_stage_ctl;

endpackage

[rtl/halfspace_triangle_coverage.sv]
// A step passes through the input register, the setup register and the result
// register, in that order; loads give no result.
// Throughput: one item per cycle while no held result stalls a step.
// The setup and input registers buffer items while a result waits.
// Reset (synchronous, active low) idles the walk, empties all stages and
// sets the target size to 640 by 480.
module halfspace_triangle_coverage #(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [htc_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_opcode,
    input  logic signed [15:0]            i_vert0_x,
    input  logic signed [15:0]            i_vert0_y,
    input  logic signed [15:0]            i_vert1_x,
    input  logic signed [15:0]            i_vert1_y,
    input  logic signed [15:0]            i_vert2_x,
    input  logic signed [15:0]            i_vert2_y,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [htc_pkg::PIX_W-1:0]     o_pixel_x,
    output logic [htc_pkg::PIX_W-1:0]     o_pixel_y,
    output logic                          o_covered,
    output logic signed [35:0]            o_edge_a,
    output logic signed [35:0]            o_edge_b,
    output logic signed [35:0]            o_edge_c,
    output logic                          o_last,
    output logic                          o_no_pixel
);

    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int RW = ((htc_pkg::VERT_W > CW + FRAC_BITS) ?
                         htc_pkg::VERT_W : CW + FRAC_BITS) + 2;

    logic [htc_pkg::DIM_W-1:0] r_width;
    logic [htc_pkg::DIM_W-1:0] r_height;

    logic           r_s0_vld;
    logic           r_s0_op;
    htc_pkg::t_vert r_s0_vx [htc_pkg::NUM_EDGES];
    htc_pkg::t_vert r_s0_vy [htc_pkg::NUM_EDGES];

    htc_pkg::t_stage_ctl  s1_ctl;
    logic [CW-1:0]        s1_left, s1_right, s1_top, s1_bottom;
    logic                 s1_walk;
    htc_pkg::t_delta      s1_dx [htc_pkg::NUM_EDGES];
    htc_pkg::t_delta      s1_dy [htc_pkg::NUM_EDGES];
    logic                 s1_bias [htc_pkg::NUM_EDGES];
    logic signed [RW-1:0] s1_relx [htc_pkg::NUM_EDGES];
    logic signed [RW-1:0] s1_rely [htc_pkg::NUM_EDGES];

    htc_pkg::t_edge out_edge [htc_pkg::NUM_EDGES];

    logic out_free;
    logic s1_adv;
    logic s1_take;
    logic s0_adv;
    logic in_xfer;

    // A load never needs the result register, so it moves on even while a
    // result is held.
    assign out_free   = !o_out_valid || i_out_ready;
    assign s1_adv     = s1_ctl.vld && (s1_ctl.is_load || out_free);
    assign s1_take    = !s1_ctl.vld || s1_adv;
    assign s0_adv     = r_s0_vld && s1_take;
    assign o_in_ready = !r_s0_vld || s1_take;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= htc_pkg::WIDTH_RST;
            r_height <= htc_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (htc_pkg::t_cfg_index'(i_cfg_index))
                htc_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                htc_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (in_xfer) begin
            r_s0_vld <= 1'b1;
        end else if (s0_adv) begin
            r_s0_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s0_op    <= i_opcode;
            r_s0_vx[0] <= i_vert0_x;
            r_s0_vy[0] <= i_vert0_y;
            r_s0_vx[1] <= i_vert1_x;
            r_s0_vy[1] <= i_vert1_y;
            r_s0_vx[2] <= i_vert2_x;
            r_s0_vy[2] <= i_vert2_y;
        end
    end

    htc_setup #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_setup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s0_adv),
        .i_adv    (s1_adv),
        .i_opcode (r_s0_op),
        .i_vx     (r_s0_vx),
        .i_vy     (r_s0_vy),
        .i_width  (r_width),
        .i_height (r_height),
        .o_ctl    (s1_ctl),
        .o_left   (s1_left),
        .o_right  (s1_right),
        .o_top    (s1_top),
        .o_bottom (s1_bottom),
        .o_walk   (s1_walk),
        .o_dx     (s1_dx),
        .o_dy     (s1_dy),
        .o_bias   (s1_bias),
        .o_relx   (s1_relx),
        .o_rely   (s1_rely)
    );

    htc_walk #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (s1_adv),
        .i_ctl       (s1_ctl),
        .i_left      (s1_left),
        .i_right     (s1_right),
        .i_top       (s1_top),
        .i_bottom    (s1_bottom),
        .i_walk      (s1_walk),
        .i_dx        (s1_dx),
        .i_dy        (s1_dy),
        .i_bias      (s1_bias),
        .i_relx      (s1_relx),
        .i_rely      (s1_rely),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_covered   (o_covered),
        .o_edge      (out_edge),
        .o_last      (o_last),
        .o_no_pixel  (o_no_pixel)
    );

    assign o_edge_a = out_edge[0];
    assign o_edge_b = out_edge[1];
    assign o_edge_c = out_edge[2];

endmodule

[rtl/htc_setup.sv]
// Setup stage: bounding box clipping, edge deltas, fill bias and vertex
// offsets from the box origin, held in the setup register.
// Depends on htc_pkg.
module htc_setup #(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 4,
    localparam int CW   = $clog2(MAX_DIM + 1),
    localparam int RW   = ((htc_pkg::VERT_W > CW + FRAC_BITS) ?
                           htc_pkg::VERT_W : CW + FRAC_BITS) + 2,
    localparam int CMPW = (htc_pkg::VERT_W > CW + 1) ? htc_pkg::VERT_W : CW + 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic                        i_adv,
    input  logic                        i_opcode,
    input  htc_pkg::t_vert              i_vx [htc_pkg::NUM_EDGES],
    input  htc_pkg::t_vert              i_vy [htc_pkg::NUM_EDGES],
    input  logic [htc_pkg::DIM_W-1:0]   i_width,
    input  logic [htc_pkg::DIM_W-1:0]   i_height,
    output htc_pkg::t_stage_ctl         o_ctl,
    output logic [CW-1:0]               o_left,
    output logic [CW-1:0]               o_right,
    output logic [CW-1:0]               o_top,
    output logic [CW-1:0]               o_bottom,
    output logic                        o_walk,
    output htc_pkg::t_delta             o_dx [htc_pkg::NUM_EDGES],
    output htc_pkg::t_delta             o_dy [htc_pkg::NUM_EDGES],
    output logic                        o_bias [htc_pkg::NUM_EDGES],
    output logic signed [RW-1:0]        o_relx [htc_pkg::NUM_EDGES],
    output logic signed [RW-1:0]        o_rely [htc_pkg::NUM_EDGES]
);

    logic                 r_vld;
    logic                 r_is_load;
    logic [CW-1:0]        r_left;
    logic [CW-1:0]        r_right;
    logic [CW-1:0]        r_top;
    logic [CW-1:0]        r_bottom;
    logic                 r_walk;
    htc_pkg::t_delta      r_dx [htc_pkg::NUM_EDGES];
    htc_pkg::t_delta      r_dy [htc_pkg::NUM_EDGES];
    logic                 r_bias [htc_pkg::NUM_EDGES];
    logic signed [RW-1:0] r_relx [htc_pkg::NUM_EDGES];
    logic signed [RW-1:0] r_rely [htc_pkg::NUM_EDGES];

    htc_pkg::t_vert         min_x, max_x, min_y, max_y;
    logic signed [CMPW-1:0] fl_min_x, fl_max_x, fl_min_y, fl_max_y;
    logic signed [CMPW-1:0] lim_x, lim_y;
    logic signed [CMPW-1:0] lo_x, hi_x, lo_y, hi_y;
    logic [CW-1:0]          n_left, n_right, n_top, n_bottom;
    logic                   n_walk;
    htc_pkg::t_delta        n_dx [htc_pkg::NUM_EDGES];
    htc_pkg::t_delta        n_dy [htc_pkg::NUM_EDGES];
    logic                   n_bias [htc_pkg::NUM_EDGES];
    logic signed [RW-1:0]   n_relx [htc_pkg::NUM_EDGES];
    logic signed [RW-1:0]   n_rely [htc_pkg::NUM_EDGES];

    function automatic htc_pkg::t_vert min3(input htc_pkg::t_vert a,
                                            input htc_pkg::t_vert b,
                                            input htc_pkg::t_vert c);
        htc_pkg::t_vert m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic htc_pkg::t_vert max3(input htc_pkg::t_vert a,
                                            input htc_pkg::t_vert b,
                                            input htc_pkg::t_vert c);
        htc_pkg::t_vert m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    always_comb begin
        min_x = min3(i_vx[0], i_vx[1], i_vx[2]);
        max_x = max3(i_vx[0], i_vx[1], i_vx[2]);
        min_y = min3(i_vy[0], i_vy[1], i_vy[2]);
        max_y = max3(i_vy[0], i_vy[1], i_vy[2]);

        // An arithmetic right shift is the floor of the fixed-point value.
        fl_min_x = CMPW'(min_x >>> FRAC_BITS);
        fl_max_x = CMPW'(max_x >>> FRAC_BITS);
        fl_min_y = CMPW'(min_y >>> FRAC_BITS);
        fl_max_y = CMPW'(max_y >>> FRAC_BITS);

        lim_x = (CMPW'(i_width) > CMPW'(MAX_DIM)) ? CMPW'(MAX_DIM) : CMPW'(i_width);
        lim_y = (CMPW'(i_height) > CMPW'(MAX_DIM)) ? CMPW'(MAX_DIM) : CMPW'(i_height);

        lo_x = (fl_min_x < 0) ? '0 : fl_min_x;
        lo_y = (fl_min_y < 0) ? '0 : fl_min_y;
        hi_x = (fl_max_x > lim_x) ? lim_x : fl_max_x;
        hi_y = (fl_max_y > lim_y) ? lim_y : fl_max_y;
        if (hi_x < 0) begin
            hi_x = '0;
        end
        if (hi_y < 0) begin
            hi_y = '0;
        end

        // The lower corner may lie beyond the target, but then the box is
        // empty and the truncated origin is never shown.
        n_walk   = (lo_x < hi_x) && (lo_y < hi_y);
        n_left   = CW'(lo_x);
        n_top    = CW'(lo_y);
        n_right  = CW'(hi_x);
        n_bottom = CW'(hi_y);

        for (int i = 0; i < htc_pkg::NUM_EDGES; i++) begin
            n_dx[i]   = htc_pkg::DELTA_W'(i_vx[i]) -
                        htc_pkg::DELTA_W'(i_vx[(i + 1) % htc_pkg::NUM_EDGES]);
            n_dy[i]   = htc_pkg::DELTA_W'(i_vy[i]) -
                        htc_pkg::DELTA_W'(i_vy[(i + 1) % htc_pkg::NUM_EDGES]);
            n_bias[i] = (n_dy[i] < 0) || ((n_dy[i] == 0) && (n_dx[i] > 0));
            n_relx[i] = RW'(i_vx[i]) - $signed(RW'(n_left) << FRAC_BITS);
            n_rely[i] = RW'(i_vy[i]) - $signed(RW'(n_top) << FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_adv) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_is_load <= (htc_pkg::t_opcode'(i_opcode) == htc_pkg::OP_LOAD);
            r_left    <= n_left;
            r_right   <= n_right;
            r_top     <= n_top;
            r_bottom  <= n_bottom;
            r_walk    <= n_walk;
            for (int i = 0; i < htc_pkg::NUM_EDGES; i++) begin
                r_dx[i]   <= n_dx[i];
                r_dy[i]   <= n_dy[i];
                r_bias[i] <= n_bias[i];
                r_relx[i] <= n_relx[i];
                r_rely[i] <= n_rely[i];
            end
        end
    end

    assign o_ctl.vld     = r_vld;
    assign o_ctl.is_load = r_is_load;
    assign o_left        = r_left;
    assign o_right       = r_right;
    assign o_top         = r_top;
    assign o_bottom      = r_bottom;
    assign o_walk        = r_walk;
    assign o_dx          = r_dx;
    assign o_dy          = r_dy;
    assign o_bias        = r_bias;
    assign o_relx        = r_relx;
    assign o_rely        = r_rely;

endmodule

[rtl/htc_walk.sv]
// Walk stage: edge constants from the setup register, the running edge
// values and walk position, and the result register.
// Depends on htc_pkg.
module htc_walk #(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 4,
    localparam int CW = $clog2(MAX_DIM + 1),
    localparam int RW = ((htc_pkg::VERT_W > CW + FRAC_BITS) ?
                         htc_pkg::VERT_W : CW + FRAC_BITS) + 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  htc_pkg::t_stage_ctl         i_ctl,
    input  logic [CW-1:0]               i_left,
    input  logic [CW-1:0]               i_right,
    input  logic [CW-1:0]               i_top,
    input  logic [CW-1:0]               i_bottom,
    input  logic                        i_walk,
    input  htc_pkg::t_delta             i_dx [htc_pkg::NUM_EDGES],
    input  htc_pkg::t_delta             i_dy [htc_pkg::NUM_EDGES],
    input  logic                        i_bias [htc_pkg::NUM_EDGES],
    input  logic signed [RW-1:0]        i_relx [htc_pkg::NUM_EDGES],
    input  logic signed [RW-1:0]        i_rely [htc_pkg::NUM_EDGES],
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [htc_pkg::PIX_W-1:0]   o_pixel_x,
    output logic [htc_pkg::PIX_W-1:0]   o_pixel_y,
    output logic                        o_covered,
    output htc_pkg::t_edge              o_edge [htc_pkg::NUM_EDGES],
    output logic                        o_last,
    output logic                        o_no_pixel
);

    htc_pkg::t_edge  r_row [htc_pkg::NUM_EDGES];
    htc_pkg::t_edge  r_cur [htc_pkg::NUM_EDGES];
    htc_pkg::t_delta r_dx [htc_pkg::NUM_EDGES];
    htc_pkg::t_delta r_dy [htc_pkg::NUM_EDGES];
    logic [CW-1:0]   r_wx;
    logic [CW-1:0]   r_wy;
    logic [CW-1:0]   r_left;
    logic [CW-1:0]   r_right;
    logic [CW-1:0]   r_bottom;
    logic            r_walking;

    logic                        r_out_vld;
    logic [htc_pkg::PIX_W-1:0]   r_px;
    logic [htc_pkg::PIX_W-1:0]   r_py;
    logic                        r_cov;
    htc_pkg::t_edge              r_oe [htc_pkg::NUM_EDGES];
    logic                        r_last;
    logic                        r_nop;

    htc_pkg::t_edge  prod_a [htc_pkg::NUM_EDGES];
    htc_pkg::t_edge  prod_b [htc_pkg::NUM_EDGES];
    htc_pkg::t_edge  n_edge0 [htc_pkg::NUM_EDGES];
    htc_pkg::t_edge  col_step [htc_pkg::NUM_EDGES];
    htc_pkg::t_edge  row_step [htc_pkg::NUM_EDGES];
    htc_pkg::t_edge  n_row_next [htc_pkg::NUM_EDGES];
    logic [CW-1:0]   wx_inc;
    logic [CW-1:0]   wy_inc;
    logic            x_more;
    logic            y_done;
    logic            all_pos;
    logic            fire_load;
    logic            fire_step;

    assign fire_load = i_fire && i_ctl.is_load;
    assign fire_step = i_fire && !i_ctl.is_load;

    always_comb begin
        // Edge value at the box origin: dy*(x_i - ox) - dx*(y_i - oy) + bias.
        for (int i = 0; i < htc_pkg::NUM_EDGES; i++) begin
            prod_a[i]     = i_dy[i] * i_relx[i];
            prod_b[i]     = i_dx[i] * i_rely[i];
            n_edge0[i]    = prod_a[i] - prod_b[i] + htc_pkg::EDGE_W'(i_bias[i]);
            col_step[i]   = htc_pkg::t_edge'(r_dy[i]) <<< FRAC_BITS;
            row_step[i]   = htc_pkg::t_edge'(r_dx[i]) <<< FRAC_BITS;
            n_row_next[i] = r_row[i] + row_step[i];
        end
        wx_inc  = r_wx + CW'(1);
        wy_inc  = r_wy + CW'(1);
        x_more  = wx_inc < r_right;
        y_done  = wy_inc >= r_bottom;
        all_pos = (r_cur[0] > 0) && (r_cur[1] > 0) && (r_cur[2] > 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walking <= 1'b0;
        end else if (fire_load) begin
            r_walking <= i_walk;
        end else if (fire_step && r_walking && !x_more && y_done) begin
            r_walking <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_load) begin
            r_wx     <= i_left;
            r_wy     <= i_top;
            r_left   <= i_left;
            r_right  <= i_right;
            r_bottom <= i_bottom;
            for (int i = 0; i < htc_pkg::NUM_EDGES; i++) begin
                r_row[i] <= n_edge0[i];
                r_cur[i] <= n_edge0[i];
                r_dx[i]  <= i_dx[i];
                r_dy[i]  <= i_dy[i];
            end
        end else if (fire_step && r_walking) begin
            if (x_more) begin
                r_wx <= wx_inc;
                for (int i = 0; i < htc_pkg::NUM_EDGES; i++) begin
                    r_cur[i] <= r_cur[i] - col_step[i];
                end
            end else begin
                r_wx <= r_left;
                r_wy <= wy_inc;
                for (int i = 0; i < htc_pkg::NUM_EDGES; i++) begin
                    r_row[i] <= n_row_next[i];
                    r_cur[i] <= n_row_next[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire_step) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_step) begin
            if (r_walking) begin
                r_px   <= htc_pkg::PIX_W'(r_wx);
                r_py   <= htc_pkg::PIX_W'(r_wy);
                r_cov  <= all_pos;
                r_last <= !x_more && y_done;
                r_nop  <= 1'b0;
                for (int i = 0; i < htc_pkg::NUM_EDGES; i++) begin
                    r_oe[i] <= r_cur[i];
                end
            end else begin
                r_px   <= '0;
                r_py   <= '0;
                r_cov  <= 1'b0;
                r_last <= 1'b0;
                r_nop  <= 1'b1;
                for (int i = 0; i < htc_pkg::NUM_EDGES; i++) begin
                    r_oe[i] <= '0;
                end
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_pixel_x   = r_px;
    assign o_pixel_y   = r_py;
    assign o_covered   = r_cov;
    assign o_edge      = r_oe;
    assign o_last      = r_last;
    assign o_no_pixel  = r_nop;

endmodule

[rtl/htc_checker.sv]
// Port-level checks for the half-space triangle coverage block, attached
// to every instance of the top level by the bind at the end of the file.
// Depends on htc_pkg.
module htc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [htc_pkg::PIX_W-1:0]     o_pixel_x,
    input logic [htc_pkg::PIX_W-1:0]     o_pixel_y,
    input logic                          o_covered,
    input logic signed [35:0]            o_edge_a,
    input logic signed [35:0]            o_edge_b,
    input logic signed [35:0]            o_edge_c,
    input logic                          o_last,
    input logic                          o_no_pixel
);

    // An empty step carries nothing but the no-pixel flag.
    a_empty_step_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_no_pixel) |->
            (!o_covered && !o_last && (o_pixel_x == '0) && (o_pixel_y == '0) &&
             (o_edge_a == '0) && (o_edge_b == '0) && (o_edge_c == '0)))
        else $error("empty step result carries pixel data");

    // Coverage must agree with the three reported edge values.
    a_covered_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_covered == ((o_edge_a > 0) && (o_edge_b > 0) && (o_edge_c > 0))))
        else $error("covered flag disagrees with edge values");

    // A held result may not vanish before its transfer.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_edge_a)))
        else $error("result dropped while stalled");

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind halfspace_triangle_coverage htc_checker u_htc_checker (.*);
